>>> rtl/dd_odom_pkg.sv
// Shared types, constants and helper functions for the differential-drive odometry block.
package dd_odom_pkg;

   // CORDIC iteration count (8 to 24)
   localparam int CORDIC_STEPS = 16;

   // Fixed-point constants
   localparam logic signed [33:0] PI_Q16      = 34'sd205888;
   localparam logic [31:0]        TWO_PI_Q16  = 32'd411775;
   localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [33:0] USEC_PER_S  = 34'sd1000000;

   // Divider runs one quotient bit per cycle over a 64-bit dividend
   localparam int DIV_BITS = 64;

   // Configuration register indexes
   localparam logic CSR_RADIUS     = 1'b0;
   localparam logic CSR_SEPARATION = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_TRAVEL,
      ST_MUL_TURN,
      ST_LOAD_TURN,
      ST_DIV_TURN,
      ST_LOAD_WRAP,
      ST_DIV_WRAP,
      ST_HEADING,
      ST_CORDIC_INIT,
      ST_CORDIC_ROT,
      ST_MUL_X,
      ST_MUL_Y,
      ST_ACC_Y,
      ST_QUAT,
      ST_MUL_LIN,
      ST_LOAD_LIN,
      ST_DIV_LIN,
      ST_MUL_ANG,
      ST_LOAD_ANG,
      ST_DIV_ANG,
      ST_DONE
   } state_type;

   // Arctangent of 2^-i in Q2.30
   function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
      logic signed [33:0] r;
      begin
         unique case (idx)
            5'd0:  r = 34'sd843314857;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043837;
            5'd3:  r = 34'sd133525159;
            5'd4:  r = 34'sd67021687;
            5'd5:  r = 34'sd33543516;
            5'd6:  r = 34'sd16775851;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194283;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048576;
            5'd11: r = 34'sd524288;
            5'd12: r = 34'sd262144;
            5'd13: r = 34'sd131072;
            5'd14: r = 34'sd65536;
            5'd15: r = 34'sd32768;
            5'd16: r = 34'sd16384;
            5'd17: r = 34'sd8192;
            5'd18: r = 34'sd4096;
            5'd19: r = 34'sd2048;
            5'd20: r = 34'sd1024;
            5'd21: r = 34'sd512;
            5'd22: r = 34'sd256;
            5'd23: r = 34'sd128;
            default: r = 34'sd0;
         endcase
         return r;
      end
   endfunction

   // Apply a sign to a magnitude and clip to signed 32 bits
   function automatic logic signed [31:0] sat_mag(input logic [63:0] mag, input logic neg);
      logic signed [31:0] r;
      begin
         if (neg) begin
            r = (mag > 64'd2147483648) ? 32'sh80000000 : 32'(~mag[31:0] + 32'd1);
         end else begin
            r = (mag > 64'd2147483647) ? 32'sh7fffffff : mag[31:0];
         end
         return r;
      end
   endfunction

endpackage

>>> rtl/diff_drive_odometry.sv
// Top level of the differential-drive odometry block: sequencer, shared multiplier,
// bit-serial divider and iterative CORDIC.
//
// Usage:
//  - req channel (tvalid/tready/tdata) takes one sample: both wheel angles, the noise
//    offset of each wheel and a microsecond stamp.
//  - rsp channel returns one pose per sample: position, heading, yaw quaternion and
//    speeds in tdata, the zero-interval flag in tuser.
//  - csr_we/csr_addr/csr_wdata write wheel radius (index 0) and separation (index 1)
//    while the block is idle.
// Processing: four passes of the restoring divider (one quotient bit per cycle) take up
// most of the time for a sample; two CORDIC runs of CORDIC_STEPS rotations each and the
// multiply and bookkeeping states make up the rest.
// req_tready is high only while the sequencer is idle; one sample is in flight at a time.
// The result sits in an output register, so the next sample is taken while the result
// waits; if the receiver still stalls when the next result is done, the sequencer holds.
// Reset (synchronous, active high) clears the pose, the stored angles and stamp, and
// restores the default radius and separation.
module diff_drive_odometry
   import dd_odom_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // Sample input
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] left_position, [63:32] right_position, [79:64] left_noise,
   // [95:80] right_noise, [127:96] stamp_us
   input  logic [127:0] req_tdata,
   // Pose output
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] pos_x, [63:32] pos_y, [82:64] heading, [98:83] quat_z, [114:99] quat_w,
   // [146:115] linear_speed, [178:147] angular_speed, [183:179] zero
   output logic [183:0] rsp_tdata,
   // [0] zero_interval
   output logic         rsp_tuser,
   // Configuration writes
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [19:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [5:0]          cnt_ff, cnt_in;
   logic                pass_ff, pass_in;
   logic [15:0]         radius_ff;
   logic [19:0]         sep_ff;
   logic signed [31:0]  prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic [31:0]         prev_stamp_ff, prev_stamp_in, dt_ff, dt_in;
   logic signed [34:0]  sum_ff, sum_in, diff_ff, diff_in;
   logic signed [31:0]  travel_ff, travel_in, turn_ff, turn_in;
   logic signed [31:0]  acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic signed [18:0]  acc_h_ff, acc_h_in;
   logic signed [31:0]  lin_ff, lin_in;
   logic signed [15:0]  qz_ff, qz_in, qw_ff, qw_in;
   logic signed [68:0]  prod_ff, prod_in;
   logic [63:0]         dvd_ff, dvd_in;
   logic [31:0]         rem_ff, rem_in, den_ff, den_in;
   logic                neg_ff, neg_in;
   logic signed [33:0]  cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic                flip_ff, flip_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [183:0]        rsp_data_ff, rsp_data_in;
   logic                rsp_zero_ff, rsp_zero_in;

   // Combinational helpers
   logic                accept;
   logic                out_free;
   logic signed [34:0]  mul_a;
   logic signed [33:0]  mul_b;
   logic signed [68:0]  prod_abs;
   logic [32:0]         div_trial;
   logic                div_ge;
   logic signed [33:0]  dl, dr;
   logic signed [31:0]  quot_sat;
   logic signed [33:0]  wrap_t;
   logic [31:0]         wrap_m;
   logic signed [33:0]  ang_raw;
   logic signed [33:0]  xs, ys;
   logic signed [33:0]  cos_v, sin_v;
   logic signed [39:0]  pos_sum;
   logic signed [31:0]  pos_sat;
   logic signed [19:0]  qz_r, qw_r;
   logic                zero_dt;
   logic signed [31:0]  ang_out;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_zero_ff;
   assign zero_dt    = (dt_ff == 32'd0);

   // Shared helper arithmetic
   always_comb begin
      prod_abs  = prod_ff[68] ? -prod_ff : prod_ff;
      div_trial = {rem_ff, dvd_ff[63]};
      div_ge    = div_trial >= {1'b0, den_ff};
      quot_sat  = sat_mag(dvd_ff, neg_ff);
      dl = 34'(signed'(req_tdata[31:0])) + 34'(signed'(req_tdata[79:64])) - 34'(prev_l_ff);
      dr = 34'(signed'(req_tdata[63:32])) + 34'(signed'(req_tdata[95:80])) - 34'(prev_r_ff);
      wrap_t = 34'(acc_h_ff) + 34'(quot_sat) + PI_Q16;
      wrap_m = (neg_ff && rem_ff != 32'd0) ? (TWO_PI_Q16 - rem_ff) : rem_ff;
      ang_raw = pass_ff ? (34'(acc_h_ff) <<< 13) : (34'(acc_h_ff) <<< 14);
      xs = cx_ff >>> cnt_ff;
      ys = cy_ff >>> cnt_ff;
      cos_v = flip_ff ? -cx_ff : cx_ff;
      sin_v = flip_ff ? -cy_ff : cy_ff;
      pos_sum = 40'(prod_ff >>> 30) + 40'(state_ff == ST_ACC_Y ? acc_y_ff : acc_x_ff);
      if (pos_sum > 40'sd2147483647) begin
         pos_sat = 32'sh7fffffff;
      end else if (pos_sum < -40'sd2147483648) begin
         pos_sat = 32'sh80000000;
      end else begin
         pos_sat = pos_sum[31:0];
      end
      qz_r = 20'((35'(sin_v) + 35'sd16384) >>> 15);
      qw_r = 20'((35'(cos_v) + 35'sd16384) >>> 15);
      ang_out = zero_dt ? 32'sd0 : quot_sat;
   end

   // Select multiplier operands
   always_comb begin
      mul_a = sum_ff;
      mul_b = 34'(signed'({1'b0, radius_ff}));
      unique case (state_ff)
         ST_MUL_TURN: mul_a = diff_ff;
         ST_MUL_X:    begin mul_a = 35'(travel_ff); mul_b = cos_v; end
         ST_MUL_Y:    begin mul_a = 35'(travel_ff); mul_b = sin_v; end
         ST_MUL_LIN:  begin mul_a = 35'(travel_ff); mul_b = USEC_PER_S; end
         ST_MUL_ANG:  begin mul_a = 35'(turn_ff);   mul_b = USEC_PER_S; end
         default:     ;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:        if (accept) state_in = ST_MUL_TRAVEL;
         ST_MUL_TRAVEL:  state_in = ST_MUL_TURN;
         ST_MUL_TURN:    state_in = ST_LOAD_TURN;
         ST_LOAD_TURN:   state_in = ST_DIV_TURN;
         ST_DIV_TURN:    if (cnt_ff == 6'(DIV_BITS - 1)) state_in = ST_LOAD_WRAP;
         ST_LOAD_WRAP:   state_in = ST_DIV_WRAP;
         ST_DIV_WRAP:    if (cnt_ff == 6'(DIV_BITS - 1)) state_in = ST_HEADING;
         ST_HEADING:     state_in = ST_CORDIC_INIT;
         ST_CORDIC_INIT: state_in = ST_CORDIC_ROT;
         ST_CORDIC_ROT:  if (cnt_ff == 6'(CORDIC_STEPS - 1))
                            state_in = pass_ff ? ST_QUAT : ST_MUL_X;
         ST_MUL_X:       state_in = ST_MUL_Y;
         ST_MUL_Y:       state_in = ST_ACC_Y;
         ST_ACC_Y:       state_in = ST_CORDIC_INIT;
         ST_QUAT:        state_in = ST_MUL_LIN;
         ST_MUL_LIN:     state_in = ST_LOAD_LIN;
         ST_LOAD_LIN:    state_in = ST_DIV_LIN;
         ST_DIV_LIN:     if (cnt_ff == 6'(DIV_BITS - 1)) state_in = ST_MUL_ANG;
         ST_MUL_ANG:     state_in = ST_LOAD_ANG;
         ST_LOAD_ANG:    state_in = ST_DIV_ANG;
         ST_DIV_ANG:     if (cnt_ff == 6'(DIV_BITS - 1)) state_in = ST_DONE;
         ST_DONE:        if (out_free) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // Datapath updates per state
   always_comb begin
      cnt_in = cnt_ff;  pass_in = pass_ff;
      prev_l_in = prev_l_ff;  prev_r_in = prev_r_ff;
      prev_stamp_in = prev_stamp_ff;  dt_in = dt_ff;
      sum_in = sum_ff;  diff_in = diff_ff;
      travel_in = travel_ff;  turn_in = turn_ff;
      acc_x_in = acc_x_ff;  acc_y_in = acc_y_ff;  acc_h_in = acc_h_ff;
      lin_in = lin_ff;  qz_in = qz_ff;  qw_in = qw_ff;
      prod_in = 69'(mul_a) * 69'(mul_b);
      dvd_in = dvd_ff;  rem_in = rem_ff;  den_in = den_ff;  neg_in = neg_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  cz_in = cz_ff;  flip_in = flip_ff;
      rsp_data_in = rsp_data_ff;  rsp_zero_in = rsp_zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            // Latch increments and store the clean sample
            if (accept) begin
               sum_in        = 35'(dl) + 35'(dr);
               diff_in       = 35'(dr) - 35'(dl);
               dt_in         = req_tdata[127:96] - prev_stamp_ff;
               prev_l_in     = req_tdata[31:0];
               prev_r_in     = req_tdata[63:32];
               prev_stamp_in = req_tdata[127:96];
            end
         end
         ST_MUL_TURN: begin
            // Travel is r*(dL+dR)/2^17 truncated toward zero
            travel_in = sat_mag(64'(prod_abs[63:17]), prod_ff[68]);
         end
         ST_LOAD_TURN, ST_LOAD_LIN, ST_LOAD_ANG: begin
            dvd_in = prod_abs[63:0];
            neg_in = prod_ff[68];
            rem_in = 32'd0;
            cnt_in = 6'd0;
            unique case (state_ff)
               ST_LOAD_TURN: den_in = (sep_ff == 20'd0) ? 32'd1 : 32'(sep_ff);
               default:      den_in = dt_ff;
            endcase
         end
         ST_DIV_TURN, ST_DIV_WRAP, ST_DIV_LIN, ST_DIV_ANG: begin
            // One restoring quotient bit per cycle
            rem_in = div_ge ? 32'(div_trial - {1'b0, den_ff}) : div_trial[31:0];
            dvd_in = {dvd_ff[62:0], div_ge};
            cnt_in = cnt_ff + 6'd1;
         end
         ST_LOAD_WRAP: begin
            // Take turn and start the modulo 2*pi reduction
            turn_in = quot_sat;
            neg_in  = wrap_t[33];
            dvd_in  = 64'(wrap_t[33] ? -wrap_t : wrap_t);
            den_in  = TWO_PI_Q16;
            rem_in  = 32'd0;
            cnt_in  = 6'd0;
         end
         ST_HEADING: begin
            acc_h_in = 19'(20'(wrap_m) - 20'(PI_Q16));
            pass_in  = 1'b0;
         end
         ST_CORDIC_INIT: begin
            // Fold the angle into [-pi/2, pi/2]
            cx_in = GAIN_Q30;
            cy_in = 34'sd0;
            cnt_in = 6'd0;
            if (ang_raw > HALF_PI_Q30) begin
               cz_in = ang_raw - PI_Q30;  flip_in = 1'b1;
            end else if (ang_raw < -HALF_PI_Q30) begin
               cz_in = ang_raw + PI_Q30;  flip_in = 1'b1;
            end else begin
               cz_in = ang_raw;  flip_in = 1'b0;
            end
         end
         ST_CORDIC_ROT: begin
            // One rotation per cycle
            if (!cz_ff[33]) begin
               cx_in = cx_ff - ys;  cy_in = cy_ff + xs;  cz_in = cz_ff - atan_q30(cnt_ff[4:0]);
            end else begin
               cx_in = cx_ff + ys;  cy_in = cy_ff - xs;  cz_in = cz_ff + atan_q30(cnt_ff[4:0]);
            end
            cnt_in = cnt_ff + 6'd1;
         end
         ST_MUL_Y: acc_x_in = pos_sat;
         ST_ACC_Y: begin
            acc_y_in = pos_sat;
            pass_in  = 1'b1;
         end
         ST_QUAT: begin
            qz_in = (qz_r > 20'sd32767) ? 16'sh7fff : (qz_r < -20'sd32768) ? 16'sh8000 : qz_r[15:0];
            qw_in = (qw_r > 20'sd32767) ? 16'sh7fff : (qw_r < -20'sd32768) ? 16'sh8000 : qw_r[15:0];
         end
         ST_MUL_ANG: lin_in = zero_dt ? 32'sd0 : quot_sat;
         ST_DONE: begin
            // Hand the pose to the output register
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_zero_in  = zero_dt;
               rsp_data_in  = {5'd0, ang_out, lin_ff, qw_ff, qz_ff, acc_h_ff, acc_y_ff, acc_x_ff};
            end
         end
         default: ;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         radius_ff     <= 16'd2163;
         sep_ff        <= 20'd11141;
         prev_l_ff     <= '0;
         prev_r_ff     <= '0;
         prev_stamp_ff <= '0;
         acc_x_ff      <= '0;
         acc_y_ff      <= '0;
         acc_h_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_l_ff     <= prev_l_in;
         prev_r_ff     <= prev_r_in;
         prev_stamp_ff <= prev_stamp_in;
         acc_x_ff      <= acc_x_in;
         acc_y_ff      <= acc_y_in;
         acc_h_ff      <= acc_h_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_RADIUS:     radius_ff <= csr_wdata[15:0];
               CSR_SEPARATION: sep_ff    <= csr_wdata;
               default:        ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      pass_ff     <= pass_in;
      dt_ff       <= dt_in;
      sum_ff      <= sum_in;
      diff_ff     <= diff_in;
      travel_ff   <= travel_in;
      turn_ff     <= turn_in;
      lin_ff      <= lin_in;
      qz_ff       <= qz_in;
      qw_ff       <= qw_in;
      prod_ff     <= prod_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      neg_ff      <= neg_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      flip_ff     <= flip_in;
      rsp_data_ff <= rsp_data_in;
      rsp_zero_ff <= rsp_zero_in;
   end

endmodule

>>> tb/tb_diff_drive_odometry.sv
// Self-checking testbench for diff_drive_odometry: directed and random samples checked against a predictor.
module tb_diff_drive_odometry;
   import dd_odom_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 1500;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [18:0] heading;
      logic [15:0] quat_z;
      logic [15:0] quat_w;
      logic [31:0] linear_speed;
      logic [31:0] angular_speed;
      logic        zero_interval;
   } pose_type;

   // Odometry predictor and queue of expected poses
   class odom_scoreboard_type;
      longint radius, separation;
      longint prev_left, prev_right, acc_x, acc_y, acc_heading;
      logic [31:0] prev_stamp;
      pose_type expected_poses[$];
      int mismatches;
      longint atan_tab[24] = '{
         843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
         16775851, 8388437, 4194283, 2097149, 1048576, 524288,
         262144, 131072, 65536, 32768, 16384, 8192,
         4096, 2048, 1024, 512, 256, 128};

      function new();
         radius = 2163; separation = 11141;
         prev_left = 0; prev_right = 0; prev_stamp = 0;
         acc_x = 0; acc_y = 0; acc_heading = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic addr, logic [19:0] value);
         if (addr == CSR_RADIUS) radius = longint'(value[15:0]);
         else separation = longint'(value);
      endfunction

      function longint clip32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint round_q15(longint v);
         longint q;
         q = (v + 16384) >>> 15;
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         return q;
      endfunction

      // Rotate a gain-compensated unit vector by an angle in Q2.30
      function void rotate(longint a, output longint c, output longint s);
         longint x, y, z, nx;
         bit flip;
         flip = 0; x = 652032874; y = 0;
         if (a > 64'sd1686629713) begin
            a = a - 64'sd3373259426; flip = 1;
         end else if (a < -64'sd1686629713) begin
            a = a + 64'sd3373259426; flip = 1;
         end
         z = a;
         for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_tab[i];
            end else begin
               nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_tab[i];
            end
            x = nx;
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      // Advance the pose for one accepted sample and queue the expected result
      function void note_sample(logic [127:0] d);
         longint left, right, nl, nr, dl, dr, sep, travel, turn, t, m, c, s, dtl;
         logic [31:0] dt;
         pose_type p;
         left = longint'($signed(d[31:0]));
         right = longint'($signed(d[63:32]));
         nl = longint'($signed(d[79:64]));
         nr = longint'($signed(d[95:80]));
         dl = left + nl - prev_left;
         dr = right + nr - prev_right;
         dt = d[127:96] - prev_stamp;
         prev_left = left; prev_right = right; prev_stamp = d[127:96];
         sep = (separation == 0) ? 1 : separation;
         travel = clip32((radius * (dl + dr)) / 131072);
         turn = clip32((radius * (dr - dl)) / sep);
         t = acc_heading + turn + 205888;
         m = t % 411775;
         if (m < 0) m = m + 411775;
         acc_heading = m - 205888;
         rotate(acc_heading * 16384, c, s);
         acc_x = clip32(acc_x + ((travel * c) >>> 30));
         acc_y = clip32(acc_y + ((travel * s) >>> 30));
         p.pos_x = acc_x[31:0];
         p.pos_y = acc_y[31:0];
         p.heading = acc_heading[18:0];
         rotate(acc_heading * 8192, c, s);
         t = round_q15(s); p.quat_z = t[15:0];
         t = round_q15(c); p.quat_w = t[15:0];
         p.zero_interval = (dt == 0);
         p.linear_speed = '0;
         p.angular_speed = '0;
         if (dt != 0) begin
            dtl = longint'(dt);
            t = clip32((travel * 1000000) / dtl); p.linear_speed = t[31:0];
            t = clip32((turn * 1000000) / dtl); p.angular_speed = t[31:0];
         end
         expected_poses.push_back(p);
      endfunction

      // Compare one accepted pose with the oldest expectation
      function void check_pose(logic [183:0] d, logic zflag);
         pose_type e, a;
         a.pos_x = d[31:0]; a.pos_y = d[63:32]; a.heading = d[82:64];
         a.quat_z = d[98:83]; a.quat_w = d[114:99];
         a.linear_speed = d[146:115]; a.angular_speed = d[178:147];
         a.zero_interval = zflag;
         if (expected_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pose transaction %h", d);
            return;
         end
         e = expected_poses.pop_front();
         if (a != e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("pose mismatch: exp x=%h y=%h hd=%h qz=%h qw=%h lin=%h ang=%h z=%b\n",
                        e.pos_x, e.pos_y, e.heading, e.quat_z, e.quat_w,
                        e.linear_speed, e.angular_speed, e.zero_interval,
                        "               got x=%h y=%h hd=%h qz=%h qw=%h lin=%h ang=%h z=%b",
                        a.pos_x, a.pos_y, a.heading, a.quat_z, a.quat_w,
                        a.linear_speed, a.angular_speed, a.zero_interval);
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [183:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_we = 0;
   logic         csr_addr = CSR_RADIUS;
   logic [19:0]  csr_wdata = '0;

   odom_scoreboard_type poses = new();
   bit idling_on = 1;
   bit hold_request = 0;
   int quiet_cycles = 0;
   logic [31:0] walk_left = 0, walk_right = 0, walk_stamp = 0;

   diff_drive_odometry dut (.*);

   always #2 clock = ~clock;

   // Record input transactions and check output transactions
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) poses.note_sample(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) poses.check_pose(rsp_tdata, rsp_tuser);
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL diff_drive_odometry");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_tready <= 1;
         @(negedge clock);
      end
   end

   task automatic send_sample(logic [31:0] l, logic [31:0] r, logic [15:0] nl,
                              logic [15:0] nr, logic [31:0] stamp);
      @(negedge clock);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {stamp, nr, nl, r, l};
      walk_left = l; walk_right = r; walk_stamp = stamp;
      do @(posedge clock); while (!req_tready);
   endtask

   // Mostly a plausible wheel walk, sometimes arbitrary values
   task automatic send_random();
      logic [31:0] l, r, st;
      if ($urandom_range(0, 3) != 0) begin
         l = walk_left + ($signed($urandom) >>> $urandom_range(8, 28));
         r = walk_right + ($signed($urandom) >>> $urandom_range(8, 28));
         case ($urandom_range(0, 15))
            0: st = walk_stamp;
            1: st = walk_stamp + $urandom;
            default: st = walk_stamp + $urandom_range(1, 20000);
         endcase
         send_sample(l, r, 16'(($urandom_range(0, 65535) >> $urandom_range(0, 15)) ^
                     ($urandom_range(0, 1) ? 32'h0000ffff : 32'h00000000)),
                     16'($urandom_range(0, 65535)), st);
      end else begin
         send_sample($urandom, $urandom, 16'($urandom), 16'($urandom), $urandom);
      end
   endtask

   // Drain, let the block settle, then write a register
   task automatic write_reg(logic addr, logic [19:0] value);
      @(negedge clock);
      req_tvalid <= 0;
      while (poses.expected_poses.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_we <= 1; csr_addr <= addr; csr_wdata <= value;
      poses.write_reg(addr, value);
      @(negedge clock);
      csr_we <= 0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: field extremes, zero interval, stamp wrap, sign swings
      send_sample(32'd0, 32'd0, 16'd0, 16'd0, 32'd0);
      send_sample(32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff, 32'd1000);
      send_sample(32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 32'd2000);
      send_sample(32'h7fffffff, 32'h80000000, 16'h7fff, 16'h8000, 32'd2000);
      send_sample(32'h80000000, 32'h7fffffff, 16'h8000, 16'h7fff, 32'hffffffff);
      send_sample(32'h00010000, 32'h00020000, 16'h0010, 16'hfff0, 32'd5);
      send_sample(32'h00020000, 32'h00010000, 16'h0000, 16'h0000, 32'd5);
      send_sample(32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff, 32'd6);
      send_sample(32'h00300000, 32'hffd00000, 16'd0, 16'd0, 32'd1006);
      send_sample(32'hffd00000, 32'h00300000, 16'd0, 16'd0, 32'd2006);
      send_sample(32'h00000000, 32'h00000000, 16'd0, 16'd0, 32'h80000000);
      for (int i = 0; i < 8; i++) send_random();

      // Extreme radius with smallest separation
      write_reg(CSR_RADIUS, 20'd65535);
      write_reg(CSR_SEPARATION, 20'd1);
      for (int i = 0; i < 110; i++) send_random();

      // Smallest radius with widest separation; long receiver hold-off midway
      write_reg(CSR_RADIUS, 20'd1);
      write_reg(CSR_SEPARATION, 20'hfffff);
      for (int i = 0; i < 110; i++) begin
         if (i == 30) hold_request = 1;
         send_random();
      end

      // Zero radius: no motion
      write_reg(CSR_RADIUS, 20'd0);
      for (int i = 0; i < 40; i++) send_random();

      // Zero separation behaves as one; upper radius bits are ignored
      write_reg(CSR_RADIUS, 20'hf0873);
      write_reg(CSR_SEPARATION, 20'd0);
      for (int i = 0; i < 80; i++) send_random();

      // Random settings
      for (int p = 0; p < 3; p++) begin
         write_reg(CSR_RADIUS, 20'($urandom_range(1, 65535)));
         write_reg(CSR_SEPARATION, 20'($urandom_range(1, 1048575)));
         for (int i = 0; i < 100; i++) send_random();
      end

      // Back to defaults, no idling on either side
      write_reg(CSR_RADIUS, 20'd2163);
      write_reg(CSR_SEPARATION, 20'd11141);
      idling_on = 0;
      for (int i = 0; i < 100; i++) send_random();

      @(negedge clock);
      req_tvalid <= 0;
      while (poses.expected_poses.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (poses.mismatches == 0 && poses.expected_poses.size() == 0) begin
         $display("PASS diff_drive_odometry");
      end else begin
         $display("FAIL diff_drive_odometry");
      end
      $finish;
   end
endmodule

>>> sim.f
rtl/dd_odom_pkg.sv
rtl/diff_drive_odometry.sv
tb/tb_diff_drive_odometry.sv
